FILE: design/keyed_cache_pin_refcount_evict_unit_defines.svh
// ---------------------------------------------------------------------------
// keyed cache assertion macros
// shared assertion forms for the keyed cache with pin and reference count
// ---------------------------------------------------------------------------
`ifndef KEYED_CACHE_PIN_REFCOUNT_EVICT_UNIT_DEFINES_SVH
`define KEYED_CACHE_PIN_REFCOUNT_EVICT_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define KCPRE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define KCPRE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/kcpre_pkg.sv
// ---------------------------------------------------------------------------
// kcpre_pkg
// shared codes, field widths and chain types of the keyed cache
// ---------------------------------------------------------------------------
`default_nettype none

package kcpre_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W        = 32;
  localparam int REFS_W       = 16;
  localparam int CMD_W        = 3;

  // operation codes of an input word
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  // broadcast commands to the cells
  localparam logic [CMD_W-1:0] CMD_NONE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DROP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_COMPACT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd4;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic              pin;
    logic [REFS_W-1:0] refs;
  } entry_t;

  typedef struct packed {
    logic   vld;
    entry_t ent;
  } slot_t;

  // command and item held by the controller, seen by every cell
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             zero_mode;
    entry_t           item;
  } bcast_t;

  // flags of the scan token that walks the chain oldest to newest
  typedef struct packed {
    logic              active;
    logic              match;
    logic              mpin;
    logic [REFS_W-1:0] mrefs;
    logic              tfound;
  } probe_t;

endpackage

`default_nettype wire

FILE: design/kcpre_cell.sv
// ---------------------------------------------------------------------------
// kcpre_cell
// one slot of the age-ordered chain with its stage of the scan token
// ---------------------------------------------------------------------------
`default_nettype none

module kcpre_cell
  import kcpre_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int INDEX    = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bcast_t                         bc,
  input  logic [$clog2(CAPACITY)-1:0]    sel_idx,
  input  logic                           lower_vld,
  input  slot_t                          upper,
  output slot_t                          slot,
  input  probe_t                         probe_in,
  input  logic [$clog2(CAPACITY)-1:0]    midx_in,
  input  logic [$clog2(CAPACITY)-1:0]    tidx_in,
  input  logic [$clog2(CAPACITY+1)-1:0]  zcnt_in,
  output probe_t                         probe_out,
  output logic [$clog2(CAPACITY)-1:0]    midx_out,
  output logic [$clog2(CAPACITY)-1:0]    tidx_out,
  output logic [$clog2(CAPACITY+1)-1:0]  zcnt_out
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic          vld;
  logic          vld_next;
  entry_t        ent;
  entry_t        ent_next;
  logic          act;
  probe_t        probe;
  probe_t        probe_next;
  logic [IW-1:0] midx;
  logic [IW-1:0] midx_next;
  logic [IW-1:0] tidx;
  logic [IW-1:0] tidx_next;
  logic [CW-1:0] zcnt;
  logic [CW-1:0] zcnt_next;

  logic sel;
  logic zero_hit;
  logic ref_hit;
  logic key_eq;

  assign sel      = (sel_idx == MY_IDX);
  assign zero_hit = vld & ~ent.pin & (ent.refs == '0);
  assign ref_hit  = vld & ~ent.pin & (ent.refs != '0);
  assign key_eq   = vld & (ent.key == bc.item.key);

  always_comb begin
    vld_next = vld;
    ent_next = ent;
    case (bc.cmd)
      CMD_WRITE: begin
        if (sel) begin
          ent_next.pin  = bc.item.pin;
          ent_next.refs = bc.item.refs;
        end
      end
      CMD_DROP: begin
        if (bc.zero_mode ? zero_hit : (ref_hit & sel)) begin
          vld_next = 1'b0;
        end
      end
      CMD_COMPACT: begin
        // a hole pulls in the slot above; a slot whose lower neighbour is a hole gives itself away
        if (!vld) begin
          vld_next = upper.vld;
          ent_next = upper.ent;
        end else if (!lower_vld) begin
          vld_next = 1'b0;
        end
      end
      CMD_INSERT: begin
        if (sel) begin
          vld_next = 1'b1;
          ent_next = bc.item;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    probe_next = probe_in;
    midx_next  = midx_in;
    tidx_next  = tidx_in;
    zcnt_next  = zcnt_in;
    // later cells are newer, so a later match overrides
    if (key_eq) begin
      probe_next.match = 1'b1;
      probe_next.mpin  = ent.pin;
      probe_next.mrefs = ent.refs;
      midx_next        = MY_IDX;
    end
    if (zero_hit) begin
      zcnt_next = zcnt_in + CW'(1);
    end
    if (ref_hit && !probe_in.tfound) begin
      probe_next.tfound = 1'b1;
      tidx_next         = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
      act <= 1'b0;
    end else begin
      vld <= vld_next;
      act <= probe_in.active;
    end
  end

  always_ff @(posedge clk) begin
    ent   <= ent_next;
    probe <= probe_next;
    midx  <= midx_next;
    tidx  <= tidx_next;
    zcnt  <= zcnt_next;
  end

  always_comb begin
    probe_out        = probe;
    probe_out.active = act;
  end

  assign slot     = '{vld: vld, ent: ent};
  assign midx_out = midx;
  assign tidx_out = tidx;
  assign zcnt_out = zcnt;

endmodule

`default_nettype wire

FILE: design/kcpre_ctrl.sv
// ---------------------------------------------------------------------------
// kcpre_ctrl
// sequencer: launches scan tokens, issues cell commands, forms results
// ---------------------------------------------------------------------------
`default_nettype none

module kcpre_ctrl
  import kcpre_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     op,
  input  logic [KEY_W-1:0]               entry_key,
  input  logic                           pin_flag,
  input  logic [REFS_W-1:0]              ref_count,
  output bcast_t                         bc,
  output logic [$clog2(CAPACITY)-1:0]    sel_idx,
  output probe_t                         launch,
  input  probe_t                         last,
  input  logic [$clog2(CAPACITY)-1:0]    last_midx,
  input  logic [$clog2(CAPACITY)-1:0]    last_tidx,
  input  logic [$clog2(CAPACITY+1)-1:0]  last_zcnt,
  output logic                           done,
  output logic                           hit,
  output logic [1:0]                     result_status,
  output logic                           found_pinned,
  output logic [REFS_W-1:0]              found_refs,
  output logic [$clog2(CAPACITY+1)-1:0]  evicted_total,
  output logic [$clog2(CAPACITY+1)-1:0]  occupancy_now
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] FULL = CW'(CAPACITY);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SCAN    = 2'd1;
  localparam logic [1:0] S_DROP    = 2'd2;
  localparam logic [1:0] S_COMPACT = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CMD_W-1:0] cmd;
  logic [CMD_W-1:0] cmd_next;
  logic             zero_mode;
  logic             zero_mode_next;
  entry_t           item;
  entry_t           item_next;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    idx_next;
  logic [1:0]       op_q;
  logic [1:0]       op_next;
  logic             launch_act;
  logic             launch_next;
  logic [CW-1:0]    occ;
  logic [CW-1:0]    occ_next;
  logic [CW-1:0]    evict;
  logic [CW-1:0]    evict_next;
  logic             done_next;
  logic             hit_next;
  logic [1:0]       status_next;
  logic             fpin_next;
  logic [REFS_W-1:0] frefs_next;

  always_comb begin
    state_next     = state;
    cmd_next       = CMD_NONE;
    zero_mode_next = zero_mode;
    item_next      = item;
    idx_next       = idx;
    op_next        = op_q;
    launch_next    = 1'b0;
    occ_next       = occ;
    evict_next     = evict;
    done_next      = 1'b0;
    hit_next       = 1'b0;
    status_next    = ST_DONE;
    fpin_next      = 1'b0;
    frefs_next     = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          op_next    = op;
          item_next  = '{key: entry_key, pin: pin_flag, refs: ref_count};
          evict_next = '0;
          case (op)
            OP_LOOKUP, OP_UPDATE: begin
              launch_next = 1'b1;
              state_next  = S_SCAN;
            end
            OP_INSERT: begin
              if (occ == FULL) begin
                launch_next = 1'b1;
                state_next  = S_SCAN;
              end else begin
                cmd_next  = CMD_INSERT;
                idx_next  = occ[IW-1:0];
                occ_next  = occ + CW'(1);
                done_next = 1'b1;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (last.active) begin
          if (op_q == OP_INSERT) begin
            if (last_zcnt != '0) begin
              cmd_next       = CMD_DROP;
              zero_mode_next = 1'b1;
              evict_next     = last_zcnt;
              occ_next       = occ - last_zcnt;
              state_next     = S_DROP;
            end else if (last.tfound) begin
              cmd_next       = CMD_DROP;
              zero_mode_next = 1'b0;
              idx_next       = last_tidx;
              evict_next     = CW'(1);
              occ_next       = occ - CW'(1);
              state_next     = S_DROP;
            end else begin
              status_next = ST_REFUSED;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end
          end else begin
            done_next  = 1'b1;
            state_next = S_IDLE;
            if (last.match) begin
              hit_next = 1'b1;
              if (op_q == OP_UPDATE) begin
                cmd_next   = CMD_WRITE;
                idx_next   = last_midx;
                fpin_next  = item.pin;
                frefs_next = item.refs;
              end else begin
                fpin_next  = last.mpin;
                frefs_next = last.mrefs;
              end
            end else begin
              status_next = ST_MISS;
            end
          end
        end
      end
      S_DROP: begin
        // the drop lands at the end of this state; the token now times the compaction
        cmd_next    = CMD_COMPACT;
        launch_next = 1'b1;
        state_next  = S_COMPACT;
      end
      S_COMPACT: begin
        cmd_next = CMD_COMPACT;
        if (last.active) begin
          cmd_next   = CMD_INSERT;
          idx_next   = occ[IW-1:0];
          occ_next   = occ + CW'(1);
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cmd        <= CMD_NONE;
      launch_act <= 1'b0;
      occ        <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      cmd        <= cmd_next;
      launch_act <= launch_next;
      occ        <= occ_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    zero_mode <= zero_mode_next;
    item      <= item_next;
    idx       <= idx_next;
    op_q      <= op_next;
    evict     <= evict_next;
    if (done_next) begin
      hit           <= hit_next;
      result_status <= status_next;
      found_pinned  <= fpin_next;
      found_refs    <= frefs_next;
      evicted_total <= evict_next;
      occupancy_now <= occ_next;
    end
  end

  assign busy    = (state != S_IDLE);
  assign bc      = '{cmd: cmd, zero_mode: zero_mode, item: item};
  assign sel_idx = idx;
  assign launch  = '{active: launch_act, match: 1'b0, mpin: 1'b0, mrefs: '0, tfound: 1'b0};

endmodule

`default_nettype wire

FILE: design/keyed_cache_pin_refcount_evict_unit.sv
// results: unused op and insert into a store with room show the result in the cycle after accept;
//   lookup, update and refused insert take one scan token pass;
//   insert into a full store takes a scan pass, a drop, a compaction pass and a write
// throughput: one word at a time; the next word may start in the cycle its result is shown
// reset: synchronous; clears the slot valid bits, occupancy and control, no clearing pass;
//   the result strobe done lasts one cycle and cannot be stalled by the receiver
// ---------------------------------------------------------------------------
// keyed_cache_pin_refcount_evict_unit
// fully associative keyed store in age order, with pinning, reference counts
// and eviction on insert into a full store, built as a chain of slot cells
// ---------------------------------------------------------------------------
`default_nettype none

`include "keyed_cache_pin_refcount_evict_unit_defines.svh"

module keyed_cache_pin_refcount_evict_unit
  import kcpre_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     op,
  input  logic [KEY_W-1:0]               entry_key,
  input  logic                           pin_flag,
  input  logic [REFS_W-1:0]              ref_count,
  output logic                           done,
  output logic                           hit,
  output logic [1:0]                     result_status,
  output logic                           found_pinned,
  output logic [REFS_W-1:0]              found_refs,
  output logic [$clog2(CAPACITY+1)-1:0]  evicted_total,
  output logic [$clog2(CAPACITY+1)-1:0]  occupancy_now
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // slot 0 holds the oldest entry; valid slots are packed from slot 0 upwards outside a drop and its compaction
  bcast_t        bc;
  logic [IW-1:0] sel_idx;
  slot_t         slots [CAPACITY];

  // scan token chain: stage 0 is the controller's launch, the last stage returns to it
  probe_t        probes [CAPACITY+1];
  logic [IW-1:0] midx   [CAPACITY+1];
  logic [IW-1:0] tidx   [CAPACITY+1];
  logic [CW-1:0] zcnt   [CAPACITY+1];

  kcpre_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .entry_key     (entry_key),
    .pin_flag      (pin_flag),
    .ref_count     (ref_count),
    .bc            (bc),
    .sel_idx       (sel_idx),
    .launch        (probes[0]),
    .last          (probes[CAPACITY]),
    .last_midx     (midx[CAPACITY]),
    .last_tidx     (tidx[CAPACITY]),
    .last_zcnt     (zcnt[CAPACITY]),
    .done          (done),
    .hit           (hit),
    .result_status (result_status),
    .found_pinned  (found_pinned),
    .found_refs    (found_refs),
    .evicted_total (evicted_total),
    .occupancy_now (occupancy_now)
  );

  // accumulators enter the chain cleared
  assign midx[0] = '0;
  assign tidx[0] = '0;
  assign zcnt[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t upper_in;
    logic  lower_in;

    // above the newest slot there is only empty space
    if (i == CAPACITY - 1) begin : g_top
      assign upper_in = '0;
    end else begin : g_mid
      assign upper_in = slots[i+1];
    end

    // below the oldest slot counts as occupied, so slot 0 never gives itself away
    if (i == 0) begin : g_bottom
      assign lower_in = 1'b1;
    end else begin : g_low
      assign lower_in = slots[i-1].vld;
    end

    kcpre_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .bc        (bc),
      .sel_idx   (sel_idx),
      .lower_vld (lower_in),
      .upper     (upper_in),
      .slot      (slots[i]),
      .probe_in  (probes[i]),
      .midx_in   (midx[i]),
      .tidx_in   (tidx[i]),
      .zcnt_in   (zcnt[i]),
      .probe_out (probes[i+1]),
      .midx_out  (midx[i+1]),
      .tidx_out  (tidx[i+1]),
      .zcnt_out  (zcnt[i+1])
    );
  end

  // a result is only shown once the sequencer is back at rest
  `KCPRE_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result shown while busy")

  // a lookup always needs a scan pass, so it cannot finish at once
  `KCPRE_ASSERT_NEXT(a_lookup_scans, clk, rst,
    start && !busy && (op == OP_LOOKUP), busy && !done, "lookup skipped scan")

  // a refused insert evicts nothing and leaves the store full
  `KCPRE_ASSERT_NOW(a_refused_full, clk, rst,
    done && (result_status == ST_REFUSED),
    (evicted_total == '0) && (occupancy_now == CW'(CAPACITY)),
    "refused insert inconsistent")

  // occupancy never passes the capacity, and a hit always reports done
  `KCPRE_ASSERT_NOW(a_occ_hit, clk, rst, done,
    (occupancy_now <= CW'(CAPACITY)) && (!hit || (result_status == ST_DONE)),
    "bad occupancy or hit status")

endmodule

`default_nettype wire
